// ===== src/kd_pkg.sv =====
// Package for the KD stochastic indicator: field widths, register indexes,
// reset values and fixed-point scale constants. No dependencies.
package kd_pkg;

    localparam int PRICE_W  = 32;
    localparam int VAL_W    = 23;
    localparam int PERIOD_W = 7;
    localparam int SPAN_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // divider geometry: quotient bits, dividend and divisor widths
    localparam int QUO_W = VAL_W;
    localparam int DVD_W = 58;
    localparam int DVS_W = 34;
    localparam int REM_W = DVS_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KSPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DSPAN  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd30;
    localparam logic [SPAN_W-1:0]   KSPAN_RST  = 4'd3;
    localparam logic [SPAN_W-1:0]   DSPAN_RST  = 4'd3;

    // 100 << 16 == 25 << 18; RSV dividend is 2*diff*100<<16 + den
    localparam int PCT_FACTOR = 25;
    localparam int PCT_SHIFT  = 19;

endpackage

// ===== src/kd_price_if.sv =====
// Price request channel: valid/ready handshake with one signed price.
// Depends on kd_pkg.
interface kd_price_if;
    logic                              valid;
    logic                              ready;
    logic signed [kd_pkg::PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

// ===== src/kd_result_if.sv =====
// Result request channel: valid/ready handshake with RSV, K, D and flags.
// Depends on kd_pkg.
interface kd_result_if;
    logic                      valid;
    logic                      ready;
    logic [kd_pkg::VAL_W-1:0]  rsv_value;
    logic [kd_pkg::VAL_W-1:0]  k_value;
    logic [kd_pkg::VAL_W-1:0]  d_value;
    logic                      flat_range;
    logic                      warm;

    modport source (output valid, output rsv_value, output k_value, output d_value,
                    output flat_range, output warm, input ready);
    modport sink   (input valid, input rsv_value, input k_value, input d_value,
                    input flat_range, input warm, output ready);
endinterface

// ===== src/kd_stochastic_indicator.sv =====
// KD stochastic indicator top level: price window memory, scan/divide sequencer.
// Depends on kd_pkg, kd_price_if and kd_result_if.
//
//  channel   dir   payload                                   handshake
//  sample    in    price (s32)                               valid/ready
//  result    out   rsv_value, k_value, d_value (u23 Q7.16),  valid/ready
//                  flat_range, warm
//  cfg       in    cfg_index (2b), cfg_data (7b)             cfg_we, no wait
//
// Each price runs through these steps from accept to the next accept:
// accept, window scan (one memory read per cycle), prep and RSV division,
// K select, K summing and division, D summing and division, final. The
// single restoring divider and the window scan take most of the time; a
// flat window skips the RSV division, warm-up items end early.
// Reset clears the sequencer and warm-up count and loads the register defaults;
// the window needs no clearing. A waiting result does not block the next price;
// a finished item holds in its last state until the output register is free.
module kd_stochastic_indicator #(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_K_SPAN = 8,
    parameter int MAX_D_SPAN = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    kd_price_if.sink                        sample,
    kd_result_if.source                     result,
    input  logic                            cfg_we,
    input  logic [kd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int CW       = $clog2(MAX_WINDOW + MAX_K_SPAN + MAX_D_SPAN);
    localparam int MAX_SPAN = (MAX_K_SPAN > MAX_D_SPAN) ? MAX_K_SPAN : MAX_D_SPAN;
    localparam int HW       = $clog2(MAX_SPAN);
    localparam int SW       = kd_pkg::VAL_W + $clog2(MAX_SPAN);
    localparam int KH       = MAX_K_SPAN - 1;
    localparam int DH       = MAX_D_SPAN - 1;
    localparam int STW      = $clog2(kd_pkg::QUO_W);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PREP, S_RDIV, S_KSEL, S_KSUM, S_KDIV,
        S_DSUM, S_DDIV, S_FIN
    } state_t;

    typedef logic [kd_pkg::VAL_W-1:0] val_t;
    typedef logic signed [kd_pkg::PRICE_W-1:0] price_t;

    // control state
    state_t                         state_reg, state_next;
    logic [AW-1:0]                  ptr_reg, ptr_next;
    logic [AW-1:0]                  scan_addr_reg, scan_addr_next;
    logic [CW-1:0]                  scan_left_reg, scan_left_next;
    logic                           pend_reg, pend_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [kd_pkg::PERIOD_W-1:0]    period_reg, period_next;
    logic [kd_pkg::SPAN_W-1:0]      kspan_reg, kspan_next;
    logic [kd_pkg::SPAN_W-1:0]      dspan_reg, dspan_next;
    logic                           out_valid_reg, out_valid_next;
    logic [STW-1:0]                 step_reg, step_next;
    logic [HW-1:0]                  hidx_reg, hidx_next;

    // payload
    price_t                         price_reg, price_next;
    price_t                         hi_reg, hi_next;
    price_t                         lo_reg, lo_next;
    price_t                         rd_data_reg;
    logic [kd_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [kd_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic [kd_pkg::DVS_W-1:0]       dvs_reg, dvs_next;
    logic [SW-1:0]                  sum_reg, sum_next;
    val_t                           khist_reg [KH];
    val_t                           khist_next [KH];
    val_t                           dhist_reg [DH];
    val_t                           dhist_next [DH];
    val_t                           rsv_reg, rsv_next;
    val_t                           kv_reg, kv_next;
    val_t                           dv_reg, dv_next;
    logic                           flat_reg, flat_next;
    logic                           warm_reg, warm_next;
    val_t                           o_rsv_reg, o_rsv_next;
    val_t                           o_kv_reg, o_kv_next;
    val_t                           o_dv_reg, o_dv_next;
    logic                           o_flat_reg, o_flat_next;
    logic                           o_warm_reg, o_warm_next;

    // price window memory
    price_t                         window_mem [MAX_WINDOW];
    logic                           mem_we;

    // effective (clamped) configuration
    logic [CW-1:0]                  n_eff, nk, nd, full, cnt_inc;

    // shared divider
    logic                           div_ld;
    logic [kd_pkg::DVD_W-1:0]       div_dvd;
    logic [kd_pkg::DVS_W-1:0]       div_dvs;
    logic [kd_pkg::REM_W-1:0]       div_trial;
    logic                           div_ge;
    val_t                           div_q;
    logic                           div_last;

    // RSV operands
    logic [kd_pkg::PRICE_W:0]       rng, diff;
    logic [kd_pkg::DVD_W-1:0]       scaled;
    logic [SW-1:0]                  sum_add;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (int'(a) == MAX_WINDOW - 1) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(MAX_WINDOW - 1) : a - 1'b1;
    endfunction

    // clamp registers to their legal ranges
    always_comb
    begin
        if (period_reg < 2)
            n_eff = CW'(2);
        else if (int'(period_reg) > MAX_WINDOW)
            n_eff = CW'(MAX_WINDOW);
        else
            n_eff = CW'(period_reg);

        if (kspan_reg < 2)
            nk = CW'(1);
        else if (int'(kspan_reg) > MAX_K_SPAN)
            nk = CW'(MAX_K_SPAN - 1);
        else
            nk = CW'(kspan_reg) - 1'b1;

        if (dspan_reg < 2)
            nd = CW'(1);
        else if (int'(dspan_reg) > MAX_D_SPAN)
            nd = CW'(MAX_D_SPAN - 1);
        else
            nd = CW'(dspan_reg) - 1'b1;

        full    = n_eff + nk + nd;
        cnt_inc = (cnt_reg < full) ? cnt_reg + 1'b1 : full;
    end

    assign rng  = {hi_reg[kd_pkg::PRICE_W-1], hi_reg} - {lo_reg[kd_pkg::PRICE_W-1], lo_reg};
    assign diff = {price_reg[kd_pkg::PRICE_W-1], price_reg}
                - {lo_reg[kd_pkg::PRICE_W-1], lo_reg};
    assign scaled = kd_pkg::DVD_W'(diff) * kd_pkg::DVD_W'(kd_pkg::PCT_FACTOR);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign div_trial = {rem_reg[kd_pkg::REM_W-2:0], quo_reg[kd_pkg::QUO_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dvs_reg});
    assign div_q     = {quo_reg[kd_pkg::QUO_W-2:0], div_ge};
    assign div_last  = (int'(step_reg) == kd_pkg::QUO_W - 1);

    assign sum_add = (state_reg == S_KSUM)
                   ? sum_reg + SW'(khist_reg[hidx_reg])
                   : sum_reg + SW'(dhist_reg[hidx_reg]);

    assign sample.ready      = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.rsv_value  = o_rsv_reg;
    assign result.k_value    = o_kv_reg;
    assign result.d_value    = o_dv_reg;
    assign result.flat_range = o_flat_reg;
    assign result.warm       = o_warm_reg;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        period_next    = period_reg;
        kspan_next     = kspan_reg;
        dspan_next     = dspan_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        step_next      = step_reg;
        hidx_next      = hidx_reg;
        price_next     = price_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        sum_next       = sum_reg;
        khist_next     = khist_reg;
        dhist_next     = dhist_reg;
        rsv_next       = rsv_reg;
        kv_next        = kv_reg;
        dv_next        = dv_reg;
        flat_next      = flat_reg;
        warm_next      = warm_reg;
        o_rsv_next     = o_rsv_reg;
        o_kv_next      = o_kv_reg;
        o_dv_next      = o_dv_reg;
        o_flat_next    = o_flat_reg;
        o_warm_next    = o_warm_reg;
        mem_we         = 1'b0;
        div_ld         = 1'b0;
        div_dvd        = '0;
        div_dvs        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    // store the new price as the newest window entry
                    ptr_next   = wrap_inc(ptr_reg);
                    mem_we     = 1'b1;
                    price_next = sample.price;
                    hi_next    = sample.price;
                    lo_next    = sample.price;
                    cnt_next   = cnt_inc;
                    rsv_next   = '0;
                    kv_next    = '0;
                    dv_next    = '0;
                    flat_next  = 1'b0;
                    warm_next  = 1'b0;
                    if (cnt_inc < n_eff)
                        state_next = S_FIN;
                    else
                    begin
                        scan_addr_next = wrap_dec(wrap_inc(ptr_reg));
                        scan_left_next = n_eff - 1'b1;
                        pend_next      = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, compare the data of the last one
                if (scan_left_reg != '0)
                begin
                    pend_next      = 1'b1;
                    scan_addr_next = wrap_dec(scan_addr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                begin
                    if (rd_data_reg > hi_reg)
                        hi_next = rd_data_reg;
                    if (rd_data_reg < lo_reg)
                        lo_next = rd_data_reg;
                end
                if (scan_left_reg == '0 && !pend_reg)
                    state_next = S_PREP;
            end

            S_PREP:
            begin
                if (hi_reg == lo_reg)
                begin
                    flat_next  = 1'b1;
                    rsv_next   = '0;
                    state_next = S_KSEL;
                end
                else
                begin
                    // round((diff * 6553600) / rng) as (2*num + rng) / (2*rng)
                    div_ld     = 1'b1;
                    div_dvd    = (scaled << kd_pkg::PCT_SHIFT) + kd_pkg::DVD_W'(rng);
                    div_dvs    = {rng, 1'b0};
                    state_next = S_RDIV;
                end
            end

            S_RDIV:
            begin
                if (div_last)
                begin
                    rsv_next   = div_q;
                    state_next = S_KSEL;
                end
            end

            S_KSEL:
            begin
                if (cnt_reg < n_eff + nk)
                begin
                    // seed K with the raw value
                    kv_next       = rsv_reg;
                    khist_next[0] = rsv_reg;
                    for (int i = 1; i < KH; i++)
                        khist_next[i] = khist_reg[i-1];
                    state_next = S_FIN;
                end
                else
                begin
                    sum_next   = SW'(rsv_reg);
                    hidx_next  = '0;
                    state_next = S_KSUM;
                end
            end

            S_KSUM, S_DSUM:
            begin
                sum_next  = sum_add;
                hidx_next = hidx_reg + 1'b1;
                if (state_reg == S_KSUM && CW'(hidx_reg) == nk - 1'b1)
                begin
                    div_ld     = 1'b1;
                    div_dvd    = kd_pkg::DVD_W'(sum_add) + kd_pkg::DVD_W'((nk + 1'b1) >> 1);
                    div_dvs    = kd_pkg::DVS_W'(nk) + 1'b1;
                    state_next = S_KDIV;
                end
                else if (state_reg == S_DSUM && CW'(hidx_reg) == nd - 1'b1)
                begin
                    div_ld     = 1'b1;
                    div_dvd    = kd_pkg::DVD_W'(sum_add) + kd_pkg::DVD_W'((nd + 1'b1) >> 1);
                    div_dvs    = kd_pkg::DVS_W'(nd) + 1'b1;
                    state_next = S_DDIV;
                end
            end

            S_KDIV:
            begin
                if (div_last)
                begin
                    kv_next       = div_q;
                    khist_next[0] = div_q;
                    for (int i = 1; i < KH; i++)
                        khist_next[i] = khist_reg[i-1];
                    if (cnt_reg < n_eff + nk + nd)
                    begin
                        // seed D with K
                        dv_next       = div_q;
                        dhist_next[0] = div_q;
                        for (int i = 1; i < DH; i++)
                            dhist_next[i] = dhist_reg[i-1];
                        state_next = S_FIN;
                    end
                    else
                    begin
                        sum_next   = SW'(div_q);
                        hidx_next  = '0;
                        state_next = S_DSUM;
                    end
                end
            end

            S_DDIV:
            begin
                if (div_last)
                begin
                    dv_next       = div_q;
                    warm_next     = 1'b1;
                    dhist_next[0] = div_q;
                    for (int i = 1; i < DH; i++)
                        dhist_next[i] = dhist_reg[i-1];
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    o_rsv_next     = rsv_reg;
                    o_kv_next      = kv_reg;
                    o_dv_next      = dv_reg;
                    o_flat_next    = flat_reg;
                    o_warm_next    = warm_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the shared divider
        if (div_ld)
        begin
            rem_next  = kd_pkg::REM_W'(div_dvd >> kd_pkg::QUO_W);
            quo_next  = div_dvd[kd_pkg::QUO_W-1:0];
            dvs_next  = div_dvs;
            step_next = '0;
        end
        else if (state_reg == S_RDIV || state_reg == S_KDIV || state_reg == S_DDIV)
        begin
            rem_next  = div_ge ? div_trial - {1'b0, dvs_reg} : div_trial;
            quo_next  = div_q;
            step_next = step_reg + 1'b1;
        end

        // register writes restart the warm-up
        if (cfg_we)
        begin
            case (cfg_index)
                kd_pkg::CFG_PERIOD:
                begin
                    period_next = cfg_data[kd_pkg::PERIOD_W-1:0];
                    cnt_next    = '0;
                end
                kd_pkg::CFG_KSPAN:
                begin
                    kspan_next = cfg_data[kd_pkg::SPAN_W-1:0];
                    cnt_next   = '0;
                end
                kd_pkg::CFG_DSPAN:
                begin
                    dspan_next = cfg_data[kd_pkg::SPAN_W-1:0];
                    cnt_next   = '0;
                end
                default:
                begin
                    cnt_next = cnt_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            scan_addr_reg <= '0;
            scan_left_reg <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            period_reg    <= kd_pkg::PERIOD_RST;
            kspan_reg     <= kd_pkg::KSPAN_RST;
            dspan_reg     <= kd_pkg::DSPAN_RST;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            hidx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            scan_addr_reg <= scan_addr_next;
            scan_left_reg <= scan_left_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            period_reg    <= period_next;
            kspan_reg     <= kspan_next;
            dspan_reg     <= dspan_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            hidx_reg      <= hidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg  <= price_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        sum_reg    <= sum_next;
        khist_reg  <= khist_next;
        dhist_reg  <= dhist_next;
        rsv_reg    <= rsv_next;
        kv_reg     <= kv_next;
        dv_reg     <= dv_next;
        flat_reg   <= flat_next;
        warm_reg   <= warm_next;
        o_rsv_reg  <= o_rsv_next;
        o_kv_reg   <= o_kv_next;
        o_dv_reg   <= o_dv_next;
        o_flat_reg <= o_flat_next;
        o_warm_reg <= o_warm_next;
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            window_mem[ptr_next] <= sample.price;
        rd_data_reg <= window_mem[scan_addr_reg];
    end

endmodule

// ===== tb/kd_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL (kd_price_if,
// kd_result_if); this file holds the shared result record type for the bench.
// Depends on kd_pkg.
package kd_tb_types;
    typedef struct packed {
        logic [kd_pkg::VAL_W-1:0] rsv_value;
        logic [kd_pkg::VAL_W-1:0] k_value;
        logic [kd_pkg::VAL_W-1:0] d_value;
        logic                     flat_range;
        logic                     warm;
    } kd_result_t;
endpackage

// ===== tb/tb_kd_stochastic_indicator.sv =====
// Testbench for kd_stochastic_indicator: drives prices under random idling,
// predicts RSV/K/D and flags per request and checks every result in order.
// Depends on kd_pkg, kd_tb_types, kd_price_if, kd_result_if and the RTL.
module tb_kd_stochastic_indicator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    // index past the register list, writes to it are ignored
    localparam logic [kd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [kd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    kd_price_if sample ();
    kd_result_if result ();

    kd_stochastic_indicator uut (
        .clk(clk), .rst_n(rst_n), .sample(sample), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state: window newest first, K/D histories newest first
    longint                    win_prices [64];
    logic [kd_pkg::VAL_W-1:0]  k_hist [7];
    logic [kd_pkg::VAL_W-1:0]  d_hist [7];
    int unsigned               seen_count;
    int unsigned               reg_period, reg_kspan, reg_dspan;
    kd_tb_types::kd_result_t   expected_q [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  fail_count = 0;
    int  idle_cycles = 0;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo,
                                             int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [kd_pkg::VAL_W-1:0] rounded_mean(
        logic [kd_pkg::VAL_W-1:0] fresh,
        logic [kd_pkg::VAL_W-1:0] hist [7], int unsigned cnt);
        longint unsigned sum;
        sum = fresh;
        for (int i = 0; i < cnt; i++)
            sum += hist[i];
        return kd_pkg::VAL_W'((sum + (cnt + 1) / 2) / (cnt + 1));
    endfunction

    // Advance the predictor by one price and return the result it implies.
    function automatic kd_tb_types::kd_result_t predict_kd(
        logic signed [kd_pkg::PRICE_W-1:0] px);
        kd_tb_types::kd_result_t r;
        int unsigned n, nk, nd, full, rank;
        longint hi, lo;
        longint unsigned num, den;
        logic [kd_pkg::VAL_W-1:0] rsv, kv, dv;
        r = '0;
        n = clamp_to(reg_period, 2, 64);
        nk = clamp_to(reg_kspan, 2, 8) - 1;
        nd = clamp_to(reg_dspan, 2, 8) - 1;
        full = n + nk + nd;
        for (int i = 63; i > 0; i--)
            win_prices[i] = win_prices[i-1];
        win_prices[0] = longint'(px);
        if (seen_count < full)
            seen_count++;
        if (seen_count < n)
            return r;
        hi = win_prices[0];
        lo = win_prices[0];
        for (int i = 1; i < n; i++)
        begin
            if (win_prices[i] > hi) hi = win_prices[i];
            if (win_prices[i] < lo) lo = win_prices[i];
        end
        rsv = '0;
        dv = '0;
        if (hi == lo)
            r.flat_range = 1'b1;
        else
        begin
            den = longint'(hi - lo);
            num = longint'(win_prices[0] - lo) * 64'd6553600;
            rsv = kd_pkg::VAL_W'((2 * num + den) / (2 * den));
        end
        rank = seen_count - n + 1;
        if (rank <= nk)
            kv = rsv;
        else
        begin
            kv = rounded_mean(rsv, k_hist, nk);
            if (rank <= nk + nd)
                dv = kv;
            else
            begin
                dv = rounded_mean(kv, d_hist, nd);
                r.warm = 1'b1;
            end
            for (int i = 6; i > 0; i--)
                d_hist[i] = d_hist[i-1];
            d_hist[0] = dv;
        end
        for (int i = 6; i > 0; i--)
            k_hist[i] = k_hist[i-1];
        k_hist[0] = kv;
        r.rsv_value = rsv;
        r.k_value = kv;
        r.d_value = dv;
        return r;
    endfunction

    initial
    begin
        sample.valid = 1'b0;
        sample.price = '0;
        result.ready = 1'b0;
    end

    // Receiver: stall at random, check each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        kd_tb_types::kd_result_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no prediction pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.rsv_value !== want.rsv_value)
                    begin
                        $error("rsv_value exp %0d got %0d", want.rsv_value, result.rsv_value);
                        fail_count++;
                    end
                    if (result.k_value !== want.k_value)
                    begin
                        $error("k_value exp %0d got %0d", want.k_value, result.k_value);
                        fail_count++;
                    end
                    if (result.d_value !== want.d_value)
                    begin
                        $error("d_value exp %0d got %0d", want.d_value, result.d_value);
                        fail_count++;
                    end
                    if (result.flat_range !== want.flat_range)
                    begin
                        $error("flat_range exp %0d got %0d", want.flat_range,
                               result.flat_range);
                        fail_count++;
                    end
                    if (result.warm !== want.warm)
                    begin
                        $error("warm exp %0d got %0d", want.warm, result.warm);
                        fail_count++;
                    end
                end
            end
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no request accepted on either channel.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one price: optional idle gap, hold valid until accepted, predict on accept.
    // Valid stays high after the accept; the next gap or a drain drops it.
    task automatic send_price(logic signed [kd_pkg::PRICE_W-1:0] px);
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sample.valid <= 1'b1;
        sample.price <= px;
        do
            @(posedge clk);
        while (!sample.ready);
        expected_q.insert(expected_q.size(), predict_kd(px));
    endtask

    task automatic wait_drained();
        sample.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Write one register while the block is idle; a write to any of the three registers restarts warm-up.
    task automatic write_reg(logic [kd_pkg::CFG_IDX_W-1:0] idx,
                             logic [kd_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kd_pkg::CFG_PERIOD: reg_period = val;
            kd_pkg::CFG_KSPAN:  reg_kspan = val[kd_pkg::SPAN_W-1:0];
            kd_pkg::CFG_DSPAN:  reg_dspan = val[kd_pkg::SPAN_W-1:0];
            default: ;
        endcase
        if (idx <= kd_pkg::CFG_DSPAN)
            seen_count = 0;
    endtask

    function automatic logic [kd_pkg::PRICE_W-1:0] rand_price(int mode);
        logic [kd_pkg::PRICE_W-1:0] base;
        base = 32'd1000;
        case (mode)
            0: return $urandom();
            1: return base + $urandom_range(50);
            default: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    // Register values straight out of reset, no idling.
    task automatic test_reset_defaults();
        for (int i = 0; i < 40; i++)
            send_price(rand_price(1));
    endtask

    // Extremes of price, flat windows, both warm-up phases, full swing.
    task automatic test_directed();
        write_reg(kd_pkg::CFG_PERIOD, 7'd2);
        write_reg(kd_pkg::CFG_KSPAN, 7'd2);
        write_reg(kd_pkg::CFG_DSPAN, 7'd2);
        send_price(32'sh8000_0000);
        send_price(32'sh8000_0000);
        send_price(32'sh7FFF_FFFF);
        send_price(32'sh8000_0000);
        send_price(32'sh7FFF_FFFF);
        send_price(32'sh7FFF_FFFF);
        send_price(32'sd0);
        send_price(-32'sd1);
        send_price(32'sd1);
        send_price(32'sh5555_5555);
        send_price(32'shAAAA_AAAA);
        send_price(32'sd12345);
    endtask

    // Random prices under a given set of register values.
    task automatic test_random_phase(int unsigned per, int unsigned ks, int unsigned ds,
                                     int count);
        write_reg(kd_pkg::CFG_PERIOD, kd_pkg::CFG_DATA_W'(per));
        write_reg(kd_pkg::CFG_KSPAN, kd_pkg::CFG_DATA_W'(ks));
        write_reg(kd_pkg::CFG_DSPAN, kd_pkg::CFG_DATA_W'(ds));
        for (int i = 0; i < count; i++)
            send_price(rand_price($urandom_range(9) < 3 ? 0 :
                                  ($urandom_range(9) < 9 ? 1 : 2)));
    endtask

    initial
    begin
        foreach (win_prices[i]) win_prices[i] = 0;
        foreach (k_hist[i]) k_hist[i] = '0;
        foreach (d_hist[i]) d_hist[i] = '0;
        seen_count = 0;
        reg_period = kd_pkg::PERIOD_RST;
        reg_kspan = kd_pkg::KSPAN_RST;
        reg_dspan = kd_pkg::DSPAN_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        send_idle_pct = 49;
        test_random_phase(64, 8, 8, 150);
        send_idle_pct = 0;
        recv_stall_pct = 49;
        test_random_phase(5, 3, 7, 150);
        // clamp below and above range, and an ignored index
        write_reg(CFG_UNUSED, 7'h7F);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random_phase(0, 15, 0, 150);
        test_random_phase(127, 0, 9, 100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_phase(3, 2, 8, 110);

        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
